FILE: rtl/sdd_pkg.sv
// sdd_pkg: shared types, codes and helpers for the sad stereo disparity block
// used by every module under rtl except sdd_frame_mem; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sdd_pkg;

  localparam int COL_W     = 9;
  localparam int ROW_W     = 8;
  localparam int PIX_W     = 8;
  localparam int COORD_W   = 12;  // signed, holds -2..1025
  localparam int DY_W      = 6;   // signed, holds +-15
  localparam int SAD_W     = 12;  // nine absolute differences
  localparam int DIVD_W    = 16;  // offset times 255
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 8;

  localparam int DEF_IMG_WIDTH  = 320;
  localparam int DEF_IMG_HEIGHT = 240;
  localparam int DEF_H_RADIUS   = 150;
  localparam int DEF_V_RADIUS   = 5;

  localparam logic [PIX_W-1:0] SCALE_MAX      = 8'd255;
  localparam logic [PIX_W-1:0] THRESHOLD_INIT = 8'd10;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_DIFF_MODE      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_THRESHOLD = 1'd1;

  typedef struct packed {
    logic             action;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] left_pixel;
    logic [PIX_W-1:0] right_pixel;
  } sdd_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] disparity;
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
  } sdd_out_t;

  // travels alongside a memory read, registered like the read data so the two arrive together
  typedef struct packed {
    logic                      lft;
    logic                      rgt;
    logic                      ok;
    logic [1:0]                iy;
    logic [1:0]                ix;
    logic                      cand;
    logic                      last;
    logic signed [COORD_W-1:0] x;
  } sdd_tag_t;

  typedef struct packed {
    logic                      done;
    logic [PIX_W-1:0]          lcenter;
    logic signed [COORD_W-1:0] best_x;
  } sdd_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LREAD,
    S_LWAIT,
    S_GATE,
    S_SCAN,
    S_DRAIN,
    S_DIV,
    S_RESULT
  } sdd_state_t;

  function automatic logic [PIX_W-1:0] pix_absdiff(input logic [PIX_W-1:0] a,
                                                   input logic [PIX_W-1:0] b);
    pix_absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sad_stereo_disparity_top.sv
// sad_stereo_disparity_top: frame stores, read sequencer, sad search and scaling
// depends on sdd_pkg, sdd_frame_mem, sdd_sad_unit, sdd_div
//
//  channel  direction  handshake             word
//  in       in         in_valid / in_stall   sdd_in_t (load or compute)
//  out      out        out_valid / out_stall sdd_out_t (one per compute)
//  cfg      in         cfg_valid / cfg_ready index + data, always ready
//
// a load leaves the block idle. a compute outside the frame reports zero; inside, it
// reads the 3x3 left kernel (9 reads), then, unless diff mode gates the centre (zero),
// streams right columns, 3 reads per column, (2*V_RADIUS+1)*(n+2) columns with
// n = min(col, H_RADIUS)+1 via the single right read port, then drains and scales.
// reset is synchronous and clears control only; frame stores need no clearing.
// a stalled result waits in the output register while the next word is taken.
`timescale 1ns / 1ps
`default_nettype none

module sad_stereo_disparity_top #(
  parameter int IMG_WIDTH  = sdd_pkg::DEF_IMG_WIDTH,
  parameter int IMG_HEIGHT = sdd_pkg::DEF_IMG_HEIGHT,
  parameter int H_RADIUS   = sdd_pkg::DEF_H_RADIUS,
  parameter int V_RADIUS   = sdd_pkg::DEF_V_RADIUS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire sdd_pkg::sdd_in_t                 in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output sdd_pkg::sdd_out_t                     out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sdd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sdd_pkg::CFG_DAT_W-1:0]    cfg_data
);

  localparam int DEPTH  = IMG_WIDTH * IMG_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CW     = sdd_pkg::COORD_W;

  sdd_pkg::sdd_state_t state, state_next;

  logic                          diff_mode;
  logic [7:0]                    diff_threshold;

  logic signed [CW-1:0]          qc, qr, cx, start_x, rx, ry;
  logic signed [sdd_pkg::DY_W-1:0] dy;
  logic [1:0]                    iy, ix;
  logic [7:0]                    disp;

  logic                          in_acc, in_frame, load_out, pix_ok;
  logic                          lread_end, scan_end, gated;
  logic [ADDR_W-1:0]             raddr, waddr;
  logic [7:0]                    left_q, right_q;

  sdd_pkg::sdd_tag_t             tag, tag_q;
  sdd_pkg::sdd_stat_t            stat;

  logic                          div_start, div_done;
  logic [sdd_pkg::DIVD_W-1:0]    div_q, div_in;
  logic [7:0]                    offset;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_mode      <= 1'b0;
      diff_threshold <= sdd_pkg::THRESHOLD_INIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sdd_pkg::REG_DIFF_MODE:      diff_mode      <= cfg_data[0];
        sdd_pkg::REG_DIFF_THRESHOLD: diff_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_acc   = in_valid && !in_stall;
  assign in_frame = (32'(in_data.col) < IMG_WIDTH) && (32'(in_data.row) < IMG_HEIGHT);
  assign waddr    = ADDR_W'(ADDR_W'(in_data.row) * ADDR_W'(IMG_WIDTH) +
                            ADDR_W'(in_data.col));

  assign start_x   = (qc > CW'(H_RADIUS)) ? (qc - CW'(H_RADIUS)) : '0;
  assign lread_end = (iy == 2'd2) && (ix == 2'd2);
  assign scan_end  = (dy == sdd_pkg::DY_W'(V_RADIUS)) &&
                     (cx == qc + CW'(1)) && (iy == 2'd2);
  assign gated     = diff_mode && (stat.lcenter <= diff_threshold);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sdd_pkg::S_IDLE: begin
        if (in_acc && in_data.action == sdd_pkg::ACT_COMPUTE) begin
          state_next = in_frame ? sdd_pkg::S_LREAD : sdd_pkg::S_RESULT;
        end
      end
      sdd_pkg::S_LREAD:  if (lread_end) state_next = sdd_pkg::S_LWAIT;
      sdd_pkg::S_LWAIT:  state_next = sdd_pkg::S_GATE;
      sdd_pkg::S_GATE:   state_next = gated ? sdd_pkg::S_RESULT : sdd_pkg::S_SCAN;
      sdd_pkg::S_SCAN:   if (scan_end) state_next = sdd_pkg::S_DRAIN;
      sdd_pkg::S_DRAIN:  if (stat.done) state_next = sdd_pkg::S_DIV;
      sdd_pkg::S_DIV:    if (div_done) state_next = sdd_pkg::S_RESULT;
      sdd_pkg::S_RESULT: if (load_out) state_next = sdd_pkg::S_IDLE;
      default:           state_next = sdd_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall  = (state != sdd_pkg::S_IDLE);
    load_out  = (state == sdd_pkg::S_RESULT) && (!out_valid || !out_stall);
    div_start = (state == sdd_pkg::S_DRAIN) && stat.done;
    if (state == sdd_pkg::S_SCAN) begin
      rx = cx;
      ry = qr + CW'(dy) + CW'(iy) - CW'(1);
    end else begin
      rx = qc + CW'(ix) - CW'(1);
      ry = qr + CW'(iy) - CW'(1);
    end
    pix_ok   = (rx >= 0) && (rx < CW'(IMG_WIDTH)) && (ry >= 0) && (ry < CW'(IMG_HEIGHT));
    raddr    = pix_ok ? ADDR_W'(ADDR_W'(ry) * ADDR_W'(IMG_WIDTH) + ADDR_W'(rx)) : '0;
    tag.lft  = (state == sdd_pkg::S_LREAD);
    tag.rgt  = (state == sdd_pkg::S_SCAN);
    tag.ok   = pix_ok;
    tag.iy   = iy;
    tag.ix   = ix;
    tag.cand = (cx >= start_x + CW'(1));
    tag.last = (state == sdd_pkg::S_SCAN) && scan_end;
    tag.x    = cx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdd_pkg::S_IDLE;
      tag_q <= '0;
    end else begin
      state <= state_next;
      tag_q <= tag;
    end
  end

  // query position and scan counters
  always_ff @(posedge clk) begin
    case (state)
      sdd_pkg::S_IDLE: begin
        if (in_acc) begin
          qc   <= CW'(in_data.col);
          qr   <= CW'(in_data.row);
          disp <= '0;
        end
        iy <= '0;
        ix <= '0;
      end
      sdd_pkg::S_LREAD: begin
        if (ix == 2'd2) begin
          ix <= '0;
          iy <= iy + 2'd1;
        end else begin
          ix <= ix + 2'd1;
        end
      end
      sdd_pkg::S_GATE: begin
        dy <= sdd_pkg::DY_W'(-V_RADIUS);
        cx <= start_x - CW'(1);
        iy <= '0;
      end
      sdd_pkg::S_SCAN: begin
        if (iy == 2'd2) begin
          iy <= '0;
          if (cx == qc + CW'(1)) begin
            cx <= start_x - CW'(1);
            dy <= dy + sdd_pkg::DY_W'(1);
          end else begin
            cx <= cx + CW'(1);
          end
        end else begin
          iy <= iy + 2'd1;
        end
      end
      sdd_pkg::S_DIV: begin
        if (div_done) disp <= div_q[7:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.disparity <= disp;
      out_data.out_col   <= qc[sdd_pkg::COL_W-1:0];
      out_data.out_row   <= qr[sdd_pkg::ROW_W-1:0];
    end
  end

  assign offset = 8'(qc - stat.best_x);
  assign div_in = sdd_pkg::DIVD_W'(offset) * sdd_pkg::DIVD_W'(sdd_pkg::SCALE_MAX);

  sdd_frame_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_left (
    .clk   (clk),
    .we    (in_acc && in_data.action == sdd_pkg::ACT_LOAD && in_frame),
    .waddr (waddr),
    .wdata (in_data.left_pixel),
    .raddr (raddr),
    .rdata (left_q)
  );

  sdd_frame_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_right (
    .clk   (clk),
    .we    (in_acc && in_data.action == sdd_pkg::ACT_LOAD && in_frame),
    .waddr (waddr),
    .wdata (in_data.right_pixel),
    .raddr (raddr),
    .rdata (right_q)
  );

  sdd_sad_unit u_sad (
    .clk        (clk),
    .rst        (rst),
    .clear      (state == sdd_pkg::S_GATE),
    .tag        (tag_q),
    .left_data  (left_q),
    .right_data (right_q),
    .stat       (stat)
  );

  sdd_div #(.DIVISOR(H_RADIUS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_in),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule

`default_nettype wire

FILE: rtl/sdd_frame_mem.sv
// sdd_frame_mem: one grey frame store, one write port, one registered read port
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module sdd_frame_mem #(
  parameter int DEPTH  = 76800,
  parameter int ADDR_W = 17
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [7:0]        wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/sdd_sad_unit.sv
// sdd_sad_unit: left kernel, sliding right window, candidate sad and running minimum
// depends on sdd_pkg
`timescale 1ns / 1ps
`default_nettype none

module sdd_sad_unit (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  clear,
  input  wire sdd_pkg::sdd_tag_t     tag,
  input  wire logic [7:0]            left_data,
  input  wire logic [7:0]            right_data,
  output sdd_pkg::sdd_stat_t         stat
);

  logic [7:0] lwin  [3][3];
  logic       lmask [3][3];
  logic [7:0] rwin  [3][3];
  logic       rmask [3][3];
  logic [7:0] colbuf [2];
  logic       colok  [2];

  logic                               win_go;
  logic                               win_last;
  logic signed [sdd_pkg::COORD_W-1:0] win_x;

  logic [sdd_pkg::SAD_W-1:0]          sad_sum;
  logic [sdd_pkg::SAD_W-1:0]          sad_q;
  logic                               sad_go;
  logic                               sad_last;
  logic signed [sdd_pkg::COORD_W-1:0] sad_x;

  logic                               have;
  logic [sdd_pkg::SAD_W-1:0]          best_sad;
  logic signed [sdd_pkg::COORD_W-1:0] best_x;
  logic                               done;

  // left kernel capture
  always_ff @(posedge clk) begin
    if (tag.lft) begin
      lwin[tag.iy][tag.ix]  <= tag.ok ? left_data : 8'd0;
      lmask[tag.iy][tag.ix] <= tag.ok;
    end
  end

  // right columns arrive top to bottom, the window shifts when a column is whole
  always_ff @(posedge clk) begin
    if (tag.rgt && tag.iy != 2'd2) begin
      colbuf[tag.iy[0]] <= right_data;
      colok[tag.iy[0]]  <= tag.ok;
    end
    if (tag.rgt && tag.iy == 2'd2) begin
      for (int r = 0; r < 3; r++) begin
        rwin[r][0]  <= rwin[r][1];
        rwin[r][1]  <= rwin[r][2];
        rmask[r][0] <= rmask[r][1];
        rmask[r][1] <= rmask[r][2];
      end
      rwin[0][2]  <= colbuf[0];
      rwin[1][2]  <= colbuf[1];
      rwin[2][2]  <= right_data;
      rmask[0][2] <= colok[0];
      rmask[1][2] <= colok[1];
      rmask[2][2] <= tag.ok;
      win_x       <= tag.x - sdd_pkg::COORD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_go   <= 1'b0;
      win_last <= 1'b0;
    end else begin
      win_go   <= tag.rgt && tag.iy == 2'd2 && tag.cand;
      win_last <= tag.rgt && tag.iy == 2'd2 && tag.last;
    end
  end

  always_comb begin
    sad_sum = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (lmask[r][c] && rmask[r][c]) begin
          sad_sum = sad_sum +
                    sdd_pkg::SAD_W'(sdd_pkg::pix_absdiff(lwin[r][c], rwin[r][c]));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    sad_q <= sad_sum;
    sad_x <= win_x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sad_go   <= 1'b0;
      sad_last <= 1'b0;
    end else begin
      sad_go   <= win_go;
      sad_last <= win_last;
    end
  end

  // first strict minimum in scan order
  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= sad_last;
      if (clear) begin
        have <= 1'b0;
      end else if (sad_go && (!have || sad_q < best_sad)) begin
        have     <= 1'b1;
        best_sad <= sad_q;
        best_x   <= sad_x;
      end
    end
  end

  assign stat.done    = done;
  assign stat.lcenter = lwin[1][1];
  assign stat.best_x  = best_x;

endmodule

`default_nettype wire

FILE: rtl/sdd_div.sv
// sdd_div: division by a constant through a registered reciprocal multiply
// depends on sdd_pkg
`timescale 1ns / 1ps
`default_nettype none

module sdd_div #(
  parameter int DIVISOR = sdd_pkg::DEF_H_RADIUS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [sdd_pkg::DIVD_W-1:0]  dividend,
  output logic                             done,
  output logic      [sdd_pkg::DIVD_W-1:0]  quotient
);

  // exact for any 16-bit dividend and a divisor below 256
  localparam int SHIFT   = sdd_pkg::DIVD_W + 8;
  localparam int RECIP_W = SHIFT + 1;
  localparam int PROD_W  = sdd_pkg::DIVD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2**SHIFT + DIVISOR - 1) / DIVISOR);

  logic [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= PROD_W'(dividend) * PROD_W'(RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  assign quotient = prod[SHIFT +: sdd_pkg::DIVD_W];

endmodule

`default_nettype wire

FILE: rtl/sdd_checker.sv
// sdd_checker: port-level checks of the disparity block, bound to the top level
// depends on sdd_pkg and sad_stereo_disparity_top
`timescale 1ns / 1ps
`default_nettype none

module sdd_checker #(
  parameter int IMG_HEIGHT = sdd_pkg::DEF_IMG_HEIGHT
) (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire sdd_pkg::sdd_in_t  in_data,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire sdd_pkg::sdd_out_t out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed under stall");

  // a load never blocks the next word
  a_load_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.action == sdd_pkg::ACT_LOAD |=> !in_stall)
    else $error("stall after load");

  // a compute stalls the input side in the cycle after it is taken
  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.action == sdd_pkg::ACT_COMPUTE |=> in_stall)
    else $error("compute did not hold input");

  // queries below the frame report zero
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && 32'(out_data.out_row) >= IMG_HEIGHT |-> out_data.disparity == '0)
    else $error("nonzero disparity outside frame");

endmodule

bind sad_stereo_disparity_top sdd_checker #(.IMG_HEIGHT(IMG_HEIGHT)) u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

FILE: dv/tb_sad_stereo_disparity_top.sv
// tb_sad_stereo_disparity_top: self-checking bench for the sad stereo disparity block
// depends on sdd_pkg and sad_stereo_disparity_top; predicts each result from its own
// copy of both frames and the diff registers, or takes a typed one from the stimulus
`timescale 1ns / 1ps

module tb_sad_stereo_disparity_top;

  localparam int WIDTH    = sdd_pkg::DEF_IMG_WIDTH;
  localparam int HEIGHT   = sdd_pkg::DEF_IMG_HEIGHT;
  localparam int HRAD     = sdd_pkg::DEF_H_RADIUS;
  localparam int VRAD     = sdd_pkg::DEF_V_RADIUS;
  localparam int NPIX     = WIDTH * HEIGHT;
  localparam int IDLE_MAX = 60000;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  sdd_pkg::sdd_in_t in_data;
  logic out_valid;
  logic out_stall;
  sdd_pkg::sdd_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [sdd_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sdd_pkg::CFG_DAT_W-1:0] cfg_data;

  sad_stereo_disparity_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [7:0] left_img [NPIX];
  logic [7:0] right_img [NPIX];
  bit written [NPIX];
  logic diff_on;
  logic [7:0] diff_thr;
  sdd_pkg::sdd_out_t pending_results[$];

  int fail_count;
  int idle_cycles;
  bit quiet_sender;
  int stall_left;
  int stall_pick;
  logic [7:0] texture [512];
  int shift;

  typedef struct {
    sdd_pkg::sdd_in_t word;
    bit typed;
    logic [7:0] disp;
  } stim_row_t;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int sad_at(int qc, int qr, int cx, int cy);
    int sum;
    int lx, ly, rx, ry, a, b;
    sum = 0;
    for (int iy = -1; iy <= 1; iy++) begin
      for (int ix = -1; ix <= 1; ix++) begin
        lx = qc + ix; ly = qr + iy; rx = cx + ix; ry = cy + iy;
        if (lx >= 0 && lx < WIDTH && ly >= 0 && ly < HEIGHT &&
            rx >= 0 && rx < WIDTH && ry >= 0 && ry < HEIGHT) begin
          a = left_img[ly*WIDTH + lx];
          b = right_img[ry*WIDTH + rx];
          sum += (a > b) ? a - b : b - a;
        end
      end
    end
    return sum;
  endfunction

  function automatic logic [7:0] predict_disparity(int qc, int qr);
    int lo, s, best_sad, best_x;
    bit have;
    if (qc >= WIDTH || qr >= HEIGHT) return 8'd0;
    if (diff_on && left_img[qr*WIDTH + qc] <= diff_thr) return 8'd0;
    lo = (qc - HRAD < 0) ? 0 : qc - HRAD;
    have = 0; best_sad = 0; best_x = qc;
    for (int dy = -VRAD; dy <= VRAD; dy++) begin
      for (int x = lo; x <= qc; x++) begin
        s = sad_at(qc, qr, x, qr + dy);
        if (!have || s < best_sad) begin
          have = 1; best_sad = s; best_x = x;
        end
      end
    end
    return 8'(((qc - best_x) * 255) / HRAD);
  endfunction

  // every pixel a compute may touch must have been loaded
  function automatic bit footprint_loaded(int qc, int qr);
    int lo;
    if (qc >= WIDTH || qr >= HEIGHT) return 1;
    lo = ((qc - HRAD < 0) ? 0 : qc - HRAD) - 1;
    for (int y = qr - VRAD - 1; y <= qr + VRAD + 1; y++) begin
      for (int x = lo; x <= qc + 1; x++) begin
        if (x >= 0 && x < WIDTH && y >= 0 && y < HEIGHT && !written[y*WIDTH + x])
          return 0;
      end
    end
    return 1;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (quiet_sender || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // hand one word over and update the predictor at the accepting edge
  task automatic send_word(input sdd_pkg::sdd_in_t w, input bit typed,
                           input logic [7:0] disp);
    int gap;
    int idx;
    sdd_pkg::sdd_out_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    if (w.action == sdd_pkg::ACT_LOAD) begin
      if (w.col < WIDTH && w.row < HEIGHT) begin
        idx = int'(w.row) * WIDTH + int'(w.col);
        left_img[idx] = w.left_pixel;
        right_img[idx] = w.right_pixel;
        written[idx] = 1;
      end
    end else begin
      res.disparity = typed ? disp : predict_disparity(int'(w.col), int'(w.row));
      res.out_col = w.col;
      res.out_row = w.row;
      pending_results.push_back(res);
    end
  endtask

  task automatic load_pixel(input int x, input int y, input bit noisy);
    sdd_pkg::sdd_in_t w;
    w.action = sdd_pkg::ACT_LOAD;
    w.col = x[8:0];
    w.row = y[7:0];
    if (noisy) begin
      w.left_pixel = 8'($urandom);
      w.right_pixel = 8'($urandom);
    end else begin
      w.left_pixel = texture[(x + 3*y) & 511];
      w.right_pixel = texture[(x + shift + 3*y) & 511];
    end
    send_word(w, 0, 8'd0);
  endtask

  function automatic sdd_pkg::sdd_in_t compute_word(int x, int y);
    sdd_pkg::sdd_in_t w;
    w.action = sdd_pkg::ACT_COMPUTE;
    w.col = x[8:0];
    w.row = y[7:0];
    w.left_pixel = 8'($urandom);
    w.right_pixel = 8'($urandom);
    return w;
  endfunction

  task automatic write_reg(input logic [sdd_pkg::CFG_IDX_W-1:0] index,
                           input logic [sdd_pkg::CFG_DAT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (index == sdd_pkg::REG_DIFF_MODE) diff_on = value[0];
    else diff_thr = value;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_items(input int count);
    int done_items, p, x, y;
    sdd_pkg::sdd_in_t w;
    done_items = 0;
    while (done_items < count) begin
      p = $urandom_range(0, 99);
      if (p < 55) begin
        if ($urandom_range(0, 3) == 0) begin
          x = $urandom_range(0, 7); y = $urandom_range(232, 239);
        end else begin
          x = $urandom_range(0, 11); y = $urandom_range(0, 9);
        end
        load_pixel(x, y, 1'($urandom_range(0, 1)));
        done_items++;
      end else if (p < 88) begin
        if ($urandom_range(0, 3) == 0) begin
          x = $urandom_range(0, 6); y = $urandom_range(238, 239);
        end else begin
          x = $urandom_range(0, 10); y = $urandom_range(0, 3);
        end
        if (!footprint_loaded(x, y)) begin
          x = 0; y = 0;
        end
        send_word(compute_word(x, y), 0, 8'd0);
        done_items++;
      end else if (p < 94) begin
        // ignored load outside the frame
        w.action = sdd_pkg::ACT_LOAD;
        if ($urandom_range(0, 1)) begin
          w.col = 9'($urandom_range(WIDTH, 511)); w.row = 8'($urandom);
        end else begin
          w.col = 9'($urandom); w.row = 8'($urandom_range(HEIGHT, 255));
        end
        w.left_pixel = 8'($urandom);
        w.right_pixel = 8'($urandom);
        send_word(w, 0, 8'd0);
      end else begin
        w = compute_word(int'($urandom_range(WIDTH, 511)), int'($urandom_range(0, 255)));
        send_word(w, 0, 8'd0);
        done_items++;
      end
    end
  endtask

  // result side
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing pending: col %0d row %0d",
               out_data.out_col, out_data.out_row);
        fail_count++;
      end else begin
        if (out_data.disparity !== pending_results[0].disparity) begin
          $error("disparity: expected %0d, got %0d",
                 pending_results[0].disparity, out_data.disparity);
          fail_count++;
        end
        if (out_data.out_col !== pending_results[0].out_col) begin
          $error("out_col: expected %0d, got %0d",
                 pending_results[0].out_col, out_data.out_col);
          fail_count++;
        end
        if (out_data.out_row !== pending_results[0].out_row) begin
          $error("out_row: expected %0d, got %0d",
                 pending_results[0].out_row, out_data.out_row);
          fail_count++;
        end
        void'(pending_results.pop_front());
      end
    end
  end

  // receiver backpressure, with quiet stretches
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 70) begin
        out_stall <= 1'b0;
      end else if (stall_pick < 95) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(10, 60);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_MAX) begin
      $display("sad_stereo_disparity_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row_item;
    sdd_pkg::sdd_in_t w;

    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fail_count = 0;
    idle_cycles = 0;
    quiet_sender = 0;
    diff_on = 1'b0;
    diff_thr = sdd_pkg::THRESHOLD_INIT;
    shift = $urandom_range(0, 8);
    foreach (texture[i]) texture[i] = 8'($urandom);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // outside-frame words need no loaded pixels
    row_item = '{compute_word(511, 255), 1, 8'd0}; rows.push_back(row_item);
    row_item = '{compute_word(WIDTH, 0), 1, 8'd0}; rows.push_back(row_item);
    row_item = '{compute_word(0, HEIGHT), 1, 8'd0}; rows.push_back(row_item);
    w = compute_word(0, 0);
    w.action = sdd_pkg::ACT_LOAD; w.col = 9'd511; w.row = 8'd255;
    w.left_pixel = 8'hff; w.right_pixel = 8'h00;
    row_item = '{w, 0, 8'd0}; rows.push_back(row_item);
    w.col = 9'd320; w.row = 8'd5; w.left_pixel = 8'h00; w.right_pixel = 8'hff;
    row_item = '{w, 0, 8'd0}; rows.push_back(row_item);
    foreach (rows[i]) send_word(rows[i].word, rows[i].typed, rows[i].disp);
    rows.delete();

    // textured patches at the top-left and bottom-left corners
    for (int y = 0; y < 10; y++)
      for (int x = 0; x < 12; x++) load_pixel(x, y, 0);
    for (int y = 232; y < HEIGHT; y++)
      for (int x = 0; x < 8; x++) load_pixel(x, y, 0);
    // extreme pixel values at both corners
    w = compute_word(0, 0);
    w.action = sdd_pkg::ACT_LOAD; w.left_pixel = 8'hff; w.right_pixel = 8'h00;
    row_item = '{w, 0, 8'd0}; rows.push_back(row_item);
    w.col = 9'd0; w.row = 8'd239; w.left_pixel = 8'h00; w.right_pixel = 8'hff;
    row_item = '{w, 0, 8'd0}; rows.push_back(row_item);
    // corners, edges, and the top row where whole windows fall off the frame
    row_item = '{compute_word(0, 0), 0, 8'd0}; rows.push_back(row_item);
    row_item = '{compute_word(10, 0), 0, 8'd0}; rows.push_back(row_item);
    row_item = '{compute_word(10, 3), 0, 8'd0}; rows.push_back(row_item);
    row_item = '{compute_word(1, 2), 0, 8'd0}; rows.push_back(row_item);
    row_item = '{compute_word(0, 239), 0, 8'd0}; rows.push_back(row_item);
    row_item = '{compute_word(6, 238), 0, 8'd0}; rows.push_back(row_item);
    foreach (rows[i]) send_word(rows[i].word, rows[i].typed, rows[i].disp);

    random_items(30);

    wait_idle();
    write_reg(sdd_pkg::REG_DIFF_MODE, 8'd1);
    write_reg(sdd_pkg::REG_DIFF_THRESHOLD, 8'd255);
    // every left level is at or below the top threshold
    send_word(compute_word(5, 5), 1, 8'd0);
    random_items(30);

    wait_idle();
    write_reg(sdd_pkg::REG_DIFF_THRESHOLD, 8'd0);
    quiet_sender = 1;
    random_items(30);
    quiet_sender = 0;

    wait_idle();
    write_reg(sdd_pkg::REG_DIFF_THRESHOLD, 8'($urandom_range(64, 192)));
    random_items(30);

    wait_idle();
    write_reg(sdd_pkg::REG_DIFF_MODE, 8'd0);
    write_reg(sdd_pkg::REG_DIFF_THRESHOLD, 8'd0);
    random_items(30);

    wait_idle();
    if (fail_count == 0) begin
      $display("sad_stereo_disparity_top regression: pass");
    end else begin
      $display("sad_stereo_disparity_top regression: fail");
    end
    $finish;
  end

endmodule

FILE: sad_stereo_disparity_top.f
rtl/sdd_pkg.sv
rtl/sdd_frame_mem.sv
rtl/sdd_sad_unit.sv
rtl/sdd_div.sv
rtl/sad_stereo_disparity_top.sv
rtl/sdd_checker.sv
dv/tb_sad_stereo_disparity_top.sv
